[hw/rtl/bikr_pkg.sv]
`default_nettype none

package bikr_pkg;

  localparam int ANG_W     = 16;  // Q3.13 angle
  localparam int SPD_W     = 16;  // Q8.8 speed / rates
  localparam int REG_W     = 16;
  localparam int CFG_IDX_W = 8;
  localparam int CW        = 32;  // CORDIC x/y/z datapath, Q2.29
  localparam int ZW        = 34;  // widened angle ahead of folding
  localparam int SC_W      = 18;  // rounded sin/cos, Q2.14
  localparam int ATAN_TAB_LEN = 20;

  localparam logic [CFG_IDX_W-1:0] CFG_INV_WB     = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_REAR_RATIO = 8'd1;

  localparam logic [REG_W-1:0] INV_WB_RST     = 16'd10240;
  localparam logic [REG_W-1:0] REAR_RATIO_RST = 16'd16384;

  localparam logic signed [ZW-1:0] Q29_HALF_PI = 34'sd843314857;
  localparam logic signed [ZW-1:0] Q29_PI      = 34'sd1686629713;
  localparam logic signed [CW-1:0] Q29_GAIN    = 32'sd326016437;

  localparam logic signed [CW-1:0] ATAN_Q29 [ATAN_TAB_LEN] = '{
    32'sd421657428, 32'sd248918915, 32'sd131521918, 32'sd66762579, 32'sd33510843,
    32'sd16771758,  32'sd8387925,   32'sd4194219,   32'sd2097141,  32'sd1048575,
    32'sd524288,    32'sd262144,    32'sd131072,    32'sd65536,    32'sd32768,
    32'sd16384,     32'sd8192,      32'sd4096,      32'sd2048,     32'sd1024
  };

  typedef struct packed {
    logic signed [ANG_W-1:0] steer_angle;
    logic signed [ANG_W-1:0] heading;
    logic signed [SPD_W-1:0] speed;
  } in_t;

  typedef struct packed {
    logic signed [SPD_W-1:0] x_rate;
    logic signed [SPD_W-1:0] y_rate;
    logic signed [SPD_W-1:0] yaw_rate;
  } out_t;

  // sin/cos of both angles plus the speed that rode along
  typedef struct packed {
    logic signed [SC_W-1:0]  sd;
    logic signed [SC_W-1:0]  cd;
    logic signed [SC_W-1:0]  sh;
    logic signed [SC_W-1:0]  ch;
    logic signed [SPD_W-1:0] speed;
  } trig_t;

  function automatic logic signed [SPD_W-1:0] sat16(input logic signed [63:0] v);
    logic signed [SPD_W-1:0] r;
    if (v > 64'sd32767) begin
      r = 16'sh7fff;
    end else if (v < -64'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = v[SPD_W-1:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

[hw/rtl/bikr_trig.sv]
`default_nettype none

module bikr_trig #(
  parameter int NSTEP = 14
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  bikr_pkg::in_t   in_req,
  output logic            trig_valid,
  output bikr_pkg::trig_t trig
);
  import bikr_pkg::*;

  logic signed [ANG_W-1:0] ang [2];
  logic signed [SC_W-1:0]  sin_r [2];
  logic signed [SC_W-1:0]  cos_r [2];
  logic [NSTEP+1:0]        vld_r;
  logic signed [SPD_W-1:0] spd_r [NSTEP+2];

  assign ang[0] = in_req.steer_angle;
  assign ang[1] = in_req.heading;

  genvar l, k;
  generate
    for (l = 0; l < 2; l++) begin : g_lane
      logic signed [ZW-1:0] z_wide;
      logic signed [ZW-1:0] z0_nxt;
      logic                 flip_nxt;
      logic signed [CW-1:0] x_r [NSTEP+1];
      logic signed [CW-1:0] y_r [NSTEP+1];
      logic signed [CW-1:0] z_r [NSTEP+1];
      logic                 flip_r [NSTEP+1];
      logic signed [CW-1:0] c_rnd;
      logic signed [CW-1:0] s_rnd;

      assign z_wide = {{(ZW-ANG_W-16){ang[l][ANG_W-1]}}, ang[l], 16'h0000};

      // fold into +/-pi/2, cosine changes sign
      always_comb begin
        z0_nxt   = z_wide;
        flip_nxt = 1'b0;
        if (z_wide > Q29_HALF_PI) begin
          z0_nxt   = Q29_PI - z_wide;
          flip_nxt = 1'b1;
        end else if (z_wide < -Q29_HALF_PI) begin
          z0_nxt   = -Q29_PI - z_wide;
          flip_nxt = 1'b1;
        end
      end

      always_ff @(posedge clk) begin
        x_r[0]    <= Q29_GAIN;
        y_r[0]    <= '0;
        z_r[0]    <= z0_nxt[CW-1:0];
        flip_r[0] <= flip_nxt;
      end

      for (k = 0; k < NSTEP; k++) begin : g_step
        always_ff @(posedge clk) begin
          flip_r[k+1] <= flip_r[k];
          if (!z_r[k][CW-1]) begin
            x_r[k+1] <= x_r[k] - (y_r[k] >>> k);
            y_r[k+1] <= y_r[k] + (x_r[k] >>> k);
            z_r[k+1] <= z_r[k] - ATAN_Q29[k];
          end else begin
            x_r[k+1] <= x_r[k] + (y_r[k] >>> k);
            y_r[k+1] <= y_r[k] - (x_r[k] >>> k);
            z_r[k+1] <= z_r[k] + ATAN_Q29[k];
          end
        end
      end

      // round Q2.29 -> Q2.14
      assign c_rnd = (x_r[NSTEP] + 32'sd16384) >>> 15;
      assign s_rnd = (y_r[NSTEP] + 32'sd16384) >>> 15;

      always_ff @(posedge clk) begin
        sin_r[l] <= s_rnd[SC_W-1:0];
        cos_r[l] <= flip_r[NSTEP] ? -c_rnd[SC_W-1:0] : c_rnd[SC_W-1:0];
      end
    end
  endgenerate

  always_ff @(posedge clk) begin
    spd_r[0] <= in_req.speed;
  end

  generate
    for (k = 0; k <= NSTEP; k++) begin : g_spd
      always_ff @(posedge clk) begin
        spd_r[k+1] <= spd_r[k];
      end
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[NSTEP:0], in_valid};
    end
  end

  assign trig_valid = vld_r[NSTEP+1];
  assign trig.sd    = sin_r[0];
  assign trig.cd    = cos_r[0];
  assign trig.sh    = sin_r[1];
  assign trig.ch    = cos_r[1];
  assign trig.speed = spd_r[NSTEP+1];

  // unit vector out of the CORDIC never grows past about 1.0 in Q2.14
  a_steer_bound: assert property (@(posedge clk) disable iff (!rst_n)
    trig_valid |-> (trig.sd <= 18'sd16400 && trig.sd >= -18'sd16400 &&
                    trig.cd <= 18'sd16400 && trig.cd >= -18'sd16400))
    else $error("steer sin/cos out of range");

  a_head_bound: assert property (@(posedge clk) disable iff (!rst_n)
    trig_valid |-> (trig.sh <= 18'sd16400 && trig.sh >= -18'sd16400 &&
                    trig.ch <= 18'sd16400 && trig.ch >= -18'sd16400))
    else $error("heading sin/cos out of range");

endmodule

`default_nettype wire

[hw/rtl/bikr_rates.sv]
`default_nettype none

module bikr_rates (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 trig_valid,
  input  bikr_pkg::trig_t      trig,
  input  logic [15:0]          inv_wb,
  input  logic [15:0]          rear_ratio,
  output logic                 out_valid,
  output bikr_pkg::out_t       out_data
);
  import bikr_pkg::*;

  localparam int P1_W  = 2 * SC_W;         // cos*cos
  localparam int RS_W  = SC_W + REG_W + 1; // rear_ratio*sin
  localparam int VS_W  = SPD_W + SC_W;     // speed*sin
  localparam int RSS_W = RS_W + SC_W;
  localparam int YP_W  = VS_W + REG_W + 1;
  localparam int TF_W  = RSS_W + 1;
  localparam int T_W   = 48;
  localparam int PX_W  = SPD_W + T_W;

  localparam logic signed [63:0] YAW_RND = 64'sd134217728;      // 2^27
  localparam logic signed [63:0] XY_RND  = 64'sd4398046511104;  // 2^42

  logic [4:0] vld_r;

  // stage 1
  logic signed [P1_W-1:0]  cc_r, cs_r;
  logic signed [RS_W-1:0]  rs_r;
  logic signed [VS_W-1:0]  vs_r;
  logic signed [SC_W-1:0]  sh1_r, ch1_r;
  logic signed [SPD_W-1:0] v1_r;
  // stage 2
  logic signed [P1_W-1:0]  cc2_r, cs2_r;
  logic signed [RSS_W-1:0] rss_r, rsc_r;
  logic signed [YP_W-1:0]  yp_r;
  logic signed [SPD_W-1:0] v2_r;
  // stage 3
  logic signed [TF_W-1:0]  tx_full, ty_full;
  logic signed [63:0]      yaw_full;
  logic signed [T_W-1:0]   tx_r, ty_r;
  logic signed [SPD_W-1:0] yaw3_r, yaw4_r;
  logic signed [SPD_W-1:0] v3_r;
  // stage 4
  logic signed [PX_W-1:0]  px_r, py_r;

  logic signed [REG_W:0] rr_s;
  logic signed [REG_W:0] iw_s;

  assign rr_s = {1'b0, rear_ratio};
  assign iw_s = {1'b0, inv_wb};

  always_ff @(posedge clk) begin
    cc_r  <= trig.cd * trig.ch;
    cs_r  <= trig.cd * trig.sh;
    rs_r  <= rr_s * trig.sd;
    vs_r  <= trig.speed * trig.sd;
    sh1_r <= trig.sh;
    ch1_r <= trig.ch;
    v1_r  <= trig.speed;
  end

  always_ff @(posedge clk) begin
    cc2_r <= cc_r;
    cs2_r <= cs_r;
    rss_r <= rs_r * sh1_r;
    rsc_r <= rs_r * ch1_r;
    yp_r  <= vs_r * iw_s;
    v2_r  <= v1_r;
  end

  assign tx_full  = (TF_W'(cc2_r) <<< 15) - TF_W'(rss_r);
  assign ty_full  = (TF_W'(cs2_r) <<< 15) + TF_W'(rsc_r);
  assign yaw_full = 64'(yp_r) + YAW_RND;

  always_ff @(posedge clk) begin
    tx_r   <= tx_full[T_W-1:0];
    ty_r   <= ty_full[T_W-1:0];
    yaw3_r <= sat16(yaw_full >>> 28);
    v3_r   <= v2_r;
  end

  always_ff @(posedge clk) begin
    px_r   <= v3_r * tx_r;
    py_r   <= v3_r * ty_r;
    yaw4_r <= yaw3_r;
  end

  always_ff @(posedge clk) begin
    out_data.x_rate   <= sat16((px_r + XY_RND) >>> 43);
    out_data.y_rate   <= sat16((py_r + XY_RND) >>> 43);
    out_data.yaw_rate <= yaw4_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[3:0], trig_valid};
    end
  end

  assign out_valid = vld_r[4];

endmodule

`default_nettype wire

[hw/rtl/kinematic_bicycle_rates_unit.sv]
// channel   | ports                            | handshake
// ----------+----------------------------------+-----------------------------------
// input     | start, busy, in_data             | request taken when start && !busy
// result    | out_valid, out_data              | one-cycle strobe, no back-pressure
// config    | cfg_valid, cfg_ready, cfg_index, | write when cfg_valid && cfg_ready
//           | cfg_wdata                        |
//
// One request per clock while busy is low. There is one CORDIC stage per iteration
// (min(CORDIC_STEPS, 20) of them), plus fold, round and five multiply/round stages.
// busy is high only during reset and the first cycle after it.
// Synchronous active-low reset clears the valid chain and loads register defaults.
// The result side cannot stall, so nothing upstream ever waits on it.
`default_nettype none

module kinematic_bicycle_rates_unit #(
  parameter int CORDIC_STEPS = 14
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  bikr_pkg::in_t                     in_data,
  output logic                              out_valid,
  output bikr_pkg::out_t                    out_data,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [bikr_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [bikr_pkg::REG_W-1:0]        cfg_wdata
);
  import bikr_pkg::*;

  localparam int NSTEP = (CORDIC_STEPS < ATAN_TAB_LEN) ? CORDIC_STEPS : ATAN_TAB_LEN;

  logic             busy_r;
  logic [REG_W-1:0] inv_wb_r;
  logic [REG_W-1:0] rear_ratio_r;
  logic             in_accept;
  logic             cfg_wr;
  logic             trig_valid;
  trig_t            trig;

  assign busy      = busy_r;
  assign cfg_ready = 1'b1;
  assign in_accept = start && !busy_r;
  assign cfg_wr    = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
    end else begin
      busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inv_wb_r     <= INV_WB_RST;
      rear_ratio_r <= REAR_RATIO_RST;
    end else if (cfg_wr) begin
      case (cfg_index)
        CFG_INV_WB:     inv_wb_r     <= cfg_wdata;
        CFG_REAR_RATIO: rear_ratio_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  bikr_trig #(
    .NSTEP (NSTEP)
  ) u_trig (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_accept),
    .in_req     (in_data),
    .trig_valid (trig_valid),
    .trig       (trig)
  );

  bikr_rates u_rates (
    .clk        (clk),
    .rst_n      (rst_n),
    .trig_valid (trig_valid),
    .trig       (trig),
    .inv_wb     (inv_wb_r),
    .rear_ratio (rear_ratio_r),
    .out_valid  (out_valid),
    .out_data   (out_data)
  );

  a_cfg_wb: assert property (@(posedge clk) disable iff (!rst_n)
    (cfg_wr && cfg_index == CFG_INV_WB) |=> inv_wb_r == $past(cfg_wdata))
    else $error("inv_wheelbase write lost");

  a_cfg_unmapped: assert property (@(posedge clk) disable iff (!rst_n)
    (cfg_wr && cfg_index != CFG_INV_WB && cfg_index != CFG_REAR_RATIO)
      |=> ($stable(inv_wb_r) && $stable(rear_ratio_r)))
    else $error("unmapped config write changed a register");

endmodule

`default_nettype wire

[dv/tb_kinematic_bicycle_rates_unit.sv]
module tb_kinematic_bicycle_rates_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import bikr_pkg::*;

  localparam int CORDIC_STEPS = 14;
  localparam int LATENCY      = (CORDIC_STEPS < ATAN_TAB_LEN ? CORDIC_STEPS : ATAN_TAB_LEN) + 7;
  localparam int DRAIN_CYCLES = LATENCY + 8;
  localparam int STALL_LIMIT  = 1000;
  localparam int NUM_PHASES   = 6;
  localparam int PHASE_ITEMS  = 280;
  localparam int QUIET_TAIL   = 150;
  localparam int PRINT_CAP    = 100;

  localparam int ANG_PI      = 25736;  // pi in Q3.13
  localparam int ANG_HALF_PI = 12868;

  localparam logic [CFG_IDX_W-1:0] CFG_IDX_TOP = 8'hFF;  // no register here

  localparam logic signed [ANG_W-1:0] CORNER_ANG [8] = '{
    16'sd0, 16'sd25736, -16'sd25736, 16'sd12868,
    16'sd12869, -16'sd12869, 16'sh7FFF, 16'sh8000
  };
  localparam logic signed [SPD_W-1:0] CORNER_SPD [4] = '{
    16'sh7FFF, 16'sh8000, 16'sd0, 16'sd256
  };

  typedef enum logic [1:0] {REQ_ITEM, REQ_CFG, REQ_IDLE} req_kind_e;

  typedef struct {
    req_kind_e             kind;
    in_t                   data;
    logic [CFG_IDX_W-1:0]  idx;
    logic [REG_W-1:0]      wdata;
    int                    count;
  } req_entry_t;

  logic                  clk;
  logic                  rst_n     = 1'b0;
  logic                  start     = 1'b0;
  logic                  busy;
  in_t                   in_data   = '0;
  logic                  out_valid;
  out_t                  out_data;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [REG_W-1:0]      cfg_wdata = '0;

  req_entry_t req_backlog [$];
  out_t       rates_due [$];
  logic [REG_W-1:0] inv_wb_copy;
  logic [REG_W-1:0] rear_ratio_copy;
  int items_taken  = 0;
  int results_seen = 0;
  int gap_left     = 0;
  int mismatches   = 0;
  int stall_cycles = 0;

  kinematic_bicycle_rates_unit #(.CORDIC_STEPS(CORDIC_STEPS)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------- predictor

  // rotation CORDIC on a Q2.29 angle, folded into +/-pi/2; sin/cos in Q2.14
  function automatic void trig_q14(input logic signed [ANG_W-1:0] ang,
                                   output longint s, output longint c);
    longint z, x, y, xs, ys;
    bit     flip;
    z = longint'(ang) * 65536;
    x = longint'(Q29_GAIN);
    y = 0;
    flip = 1'b0;
    if (z > longint'(Q29_HALF_PI)) begin
      z = longint'(Q29_PI) - z;
      flip = 1'b1;
    end else if (z < -longint'(Q29_HALF_PI)) begin
      z = -longint'(Q29_PI) - z;
      flip = 1'b1;
    end
    for (int i = 0; i < CORDIC_STEPS && i < ATAN_TAB_LEN; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (z >= 0) begin
        x = x - ys;
        y = y + xs;
        z = z - longint'(ATAN_Q29[i]);
      end else begin
        x = x + ys;
        y = y - xs;
        z = z + longint'(ATAN_Q29[i]);
      end
    end
    c = (x + 16384) >>> 15;
    s = (y + 16384) >>> 15;
    if (flip) c = -c;
  endfunction

  function automatic logic signed [SPD_W-1:0] clip16(input longint v);
    if (v > 32767) return 16'sh7FFF;
    if (v < -32768) return 16'sh8000;
    return v[SPD_W-1:0];
  endfunction

  function automatic out_t bicycle_rates(input in_t req, input logic [REG_W-1:0] inv_wb,
                                         input logic [REG_W-1:0] rr_q15);
    longint sd, cd, sh, ch, v, iw, rr, tx, ty;
    out_t   res;
    trig_q14(req.steer_angle, sd, cd);
    trig_q14(req.heading, sh, ch);
    v  = longint'(req.speed);
    iw = longint'({48'd0, inv_wb});
    rr = longint'({48'd0, rr_q15});
    tx = cd * ch * 32768 - rr * sd * sh;
    ty = cd * sh * 32768 + rr * sd * ch;
    res.x_rate   = clip16((v * tx + (longint'(1) <<< 42)) >>> 43);
    res.y_rate   = clip16((v * ty + (longint'(1) <<< 42)) >>> 43);
    res.yaw_rate = clip16((v * sd * iw + (longint'(1) <<< 27)) >>> 28);
    return res;
  endfunction

  // ---------------------------------------------------------------- stimulus

  function automatic logic signed [ANG_W-1:0] pick_angle();
    int r;
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 3) begin
      r = $urandom_range(0, 65535);
    end else if (sel < 7) begin
      r = $urandom_range(0, 2 * ANG_PI) - ANG_PI;
    end else if (sel < 9) begin
      // around the folding points
      r = ($urandom_range(0, 1) ? ANG_PI : ANG_HALF_PI) + $urandom_range(0, 8) - 4;
      if ($urandom_range(0, 1)) r = -r;
    end else begin
      r = $urandom_range(0, 64) - 32;
    end
    return r[ANG_W-1:0];
  endfunction

  function automatic logic signed [SPD_W-1:0] pick_speed();
    int r;
    if ($urandom_range(0, 9) == 0) r = $urandom_range(0, 1) ? 32767 : -32768;
    else r = $urandom_range(0, 65535);
    return r[SPD_W-1:0];
  endfunction

  task automatic queue_item(input in_t req, input bit allow_idle);
    req_entry_t e;
    e = '{kind: REQ_IDLE, data: '0, idx: '0, wdata: '0, count: 0};
    if (allow_idle && $urandom_range(0, 4) == 0) begin
      e.count = $urandom_range(1, 8);
      req_backlog.push_back(e);
    end
    e.kind = REQ_ITEM;
    e.data = req;
    req_backlog.push_back(e);
  endtask

  task automatic queue_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [REG_W-1:0] val);
    req_entry_t e;
    e = '{kind: REQ_CFG, data: '0, idx: idx, wdata: val, count: 0};
    req_backlog.push_back(e);
  endtask

  task automatic flag_mismatch(input string what);
    mismatches++;
    if (mismatches <= PRINT_CAP) $display("%0t ns: %s", $realtime, what);
  endtask

  // ---------------------------------------------------------------- driver

  always @(posedge clk) begin : req_driver
    req_entry_t            head;
    logic                  nxt_start;
    logic                  nxt_cfg;
    in_t                   nxt_data;
    logic [CFG_IDX_W-1:0]  nxt_idx;
    logic [REG_W-1:0]      nxt_wdata;
    nxt_start = 1'b0;
    nxt_cfg   = 1'b0;
    nxt_data  = in_data;
    nxt_idx   = cfg_index;
    nxt_wdata = cfg_wdata;
    if (!rst_n) begin
      inv_wb_copy     = INV_WB_RST;
      rear_ratio_copy = REAR_RATIO_RST;
      gap_left        = 0;
    end else begin
      if (start && !busy) begin
        rates_due.push_back(bicycle_rates(in_data, inv_wb_copy, rear_ratio_copy));
        items_taken++;
        void'(req_backlog.pop_front());
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_INV_WB:     inv_wb_copy = cfg_wdata;
          CFG_REAR_RATIO: rear_ratio_copy = cfg_wdata;
          default: ;
        endcase
        void'(req_backlog.pop_front());
      end
      if (gap_left > 0) begin
        gap_left--;
      end else if (req_backlog.size() > 0) begin
        head = req_backlog[0];
        case (head.kind)
          REQ_IDLE: begin
            gap_left = head.count - 1;
            void'(req_backlog.pop_front());
          end
          REQ_ITEM: begin
            nxt_start = 1'b1;
            nxt_data  = head.data;
          end
          REQ_CFG: begin
            // registers change only with nothing in flight
            if (results_seen >= items_taken) begin
              nxt_cfg   = 1'b1;
              nxt_idx   = head.idx;
              nxt_wdata = head.wdata;
            end
          end
          default: ;
        endcase
      end
    end
    start     <= nxt_start;
    in_data   <= nxt_data;
    cfg_valid <= nxt_cfg;
    cfg_index <= nxt_idx;
    cfg_wdata <= nxt_wdata;
  end

  // ---------------------------------------------------------------- monitor

  always @(posedge clk) begin : rate_monitor
    out_t want;
    if (rst_n && out_valid) begin
      if (rates_due.size() == 0) begin
        flag_mismatch($sformatf("result with no request pending: x %0d y %0d yaw %0d",
                                out_data.x_rate, out_data.y_rate, out_data.yaw_rate));
      end else begin
        want = rates_due.pop_front();
        if (out_data.x_rate !== want.x_rate)
          flag_mismatch($sformatf("x_rate got %0d want %0d", out_data.x_rate, want.x_rate));
        if (out_data.y_rate !== want.y_rate)
          flag_mismatch($sformatf("y_rate got %0d want %0d", out_data.y_rate, want.y_rate));
        if (out_data.yaw_rate !== want.yaw_rate)
          flag_mismatch($sformatf("yaw_rate got %0d want %0d",
                                  out_data.yaw_rate, want.yaw_rate));
      end
      results_seen <= results_seen + 1;
    end
  end

  always @(posedge clk) begin : watchdog
    if (!rst_n || (start && !busy) || (cfg_valid && cfg_ready) || out_valid) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("kinematic_bicycle_rates_unit: mismatch");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // ---------------------------------------------------------------- sequence

  initial begin : run
    in_t req;
    bit  quiet;
    int  left;

    // corner angles and speeds under the reset register values
    for (int k = 0; k < 8; k++) begin
      req.steer_angle = CORNER_ANG[k];
      req.heading     = CORNER_ANG[(k + 3) % 8];
      req.speed       = CORNER_SPD[k % 4];
      queue_item(req, 1'b1);
    end
    for (int k = 0; k < 8; k++) begin
      req.steer_angle = CORNER_ANG[k];
      req.heading     = CORNER_ANG[7 - k];
      req.speed       = k[0] ? 16'sh8000 : 16'sh7FFF;
      queue_item(req, 1'b0);
    end
    // largest inv_wb, rear_ratio at 0x8000: yaw_rate saturates
    queue_cfg(CFG_INV_WB, 16'hFFFF);
    queue_cfg(CFG_REAR_RATIO, 16'h8000);
    for (int k = 0; k < 4; k++) begin
      req.steer_angle = k[0] ? -16'(ANG_HALF_PI) : 16'(ANG_HALF_PI);
      req.heading     = k[1] ? 16'(ANG_HALF_PI) : 16'sd0;
      req.speed       = k[0] ? 16'sh8000 : 16'sh7FFF;
      queue_item(req, 1'b0);
    end

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        0: begin
          queue_cfg(CFG_INV_WB, 16'h0000);
          queue_cfg(CFG_REAR_RATIO, 16'h0000);
        end
        1: begin
          queue_cfg(CFG_INV_WB, 16'hFFFF);
          queue_cfg(CFG_REAR_RATIO, 16'h8000);
        end
        2: begin
          // rear_ratio above 0x8000, plus a write to nowhere
          queue_cfg(CFG_REAR_RATIO, 16'hFFFF);
          queue_cfg(8'($urandom_range(2, 254)), 16'($urandom));
        end
        3: begin
          queue_cfg(CFG_INV_WB, 16'($urandom));
          queue_cfg(CFG_REAR_RATIO, 16'($urandom_range(0, 32768)));
        end
        4: begin
          queue_cfg(CFG_REAR_RATIO, 16'($urandom));
          queue_cfg(CFG_IDX_TOP, 16'($urandom));
          queue_cfg(CFG_INV_WB, 16'($urandom));
        end
        default: begin
          queue_cfg(CFG_INV_WB, INV_WB_RST);
          queue_cfg(CFG_REAR_RATIO, REAR_RATIO_RST);
        end
      endcase
      quiet = 1'b0;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (n % 40 == 0) quiet = ($urandom_range(0, 3) == 0);
        left = (NUM_PHASES - 1 - ph) * PHASE_ITEMS + (PHASE_ITEMS - n);
        req.steer_angle = pick_angle();
        req.heading     = pick_angle();
        req.speed       = pick_speed();
        queue_item(req, !quiet && left > QUIET_TAIL);
      end
    end

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    while (req_backlog.size() != 0 || results_seen < items_taken) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (rates_due.size() != 0)
      flag_mismatch($sformatf("%0d results never arrived", rates_due.size()));
    if (mismatches == 0) begin
      $display("kinematic_bicycle_rates_unit: match");
    end else begin
      $display("kinematic_bicycle_rates_unit: mismatch");
    end
    $finish;
  end

endmodule
